[src/fcs_pkg.sv]
// Shared types, codes and constants of the flash command sequencer.
package fcs_pkg;

   localparam int unsigned WORD_W = 32;

   // Input op codes
   localparam logic [1:0] REQ_TICK   = 2'd0;
   localparam logic [1:0] REQ_PROG   = 2'd1;
   localparam logic [1:0] REQ_ERASE  = 2'd2;
   localparam logic [1:0] REQ_VERIFY = 2'd3;

   // Operation codes, also the index of the per-operation state
   localparam logic [1:0] OPC_PROG   = 2'd0;
   localparam logic [1:0] OPC_ERASE  = 2'd1;
   localparam logic [1:0] OPC_VERIFY = 2'd2;
   localparam int unsigned NUM_OPS = 3;

   // Service order of the operation machines on a tick
   localparam logic [1:0] OP_ORDER [NUM_OPS] = '{OPC_ERASE, OPC_VERIFY, OPC_PROG};

   // Result kinds
   localparam logic [2:0] KIND_REPLY  = 3'd0;
   localparam logic [2:0] KIND_KEY    = 3'd1;
   localparam logic [2:0] KIND_START  = 3'd2;
   localparam logic [2:0] KIND_DATA   = 3'd3;
   localparam logic [2:0] KIND_CLEAR  = 3'd4;
   localparam logic [2:0] KIND_RELOCK = 3'd5;
   localparam logic [2:0] KIND_DONE   = 3'd6;

   // Result codes
   localparam logic [2:0] RC_DEFAULT  = 3'd0;
   localparam logic [2:0] RC_OK       = 3'd1;
   localparam logic [2:0] RC_BUSY     = 3'd2;
   localparam logic [2:0] RC_ADDR_ERR = 3'd3;
   localparam logic [2:0] RC_ERROR    = 3'd4;

   // Unlock keys
   localparam logic [WORD_W-1:0] KEY_FIRST  = 32'h00ac_7811;
   localparam logic [WORD_W-1:0] KEY_SECOND = 32'h0123_4567;

   // Configuration registers
   localparam logic CSR_FLASH_BASE = 1'b0;
   localparam logic CSR_FLASH_END  = 1'b1;
   localparam logic [WORD_W-1:0] FLASH_BASE_RESET = 32'h0800_0000;
   localparam logic [WORD_W-1:0] FLASH_END_RESET  = 32'h0802_0000;

   // Command queue between front and back
   localparam int unsigned CMDQ_DEPTH = 4;
   localparam logic [2:0]  CMDQ_FULL  = 3'd4;

   // Result queue in the back part; a command commits only with room for two results
   localparam int unsigned RESQ_DEPTH = 4;
   localparam logic [2:0]  RESQ_ROOM  = 3'd2;

   // One-hot phases, shared by the unlock machine and the operation machines
   typedef enum logic [3:0] {
      PH_IDLE  = 4'b0001,
      PH_CHECK = 4'b0010,
      PH_WAIT  = 4'b0100,
      PH_OVER  = 4'b1000
   } phase_type;

   typedef struct packed {
      logic              is_req;
      logic [1:0]        req_op;
      logic [WORD_W-1:0] address;
      logic [WORD_W-1:0] word;
      logic              ctrl_locked;
      logic              ctrl_busy;
      logic              end_of_op;
      logic [2:0]        fault;      // indexed by operation code
   } fcs_cmd_type;

   typedef struct packed {
      logic [2:0]        kind;
      logic [WORD_W-1:0] target;
      logic [WORD_W-1:0] payload;
      logic [1:0]        operation;
      logic [2:0]        result_code;
      logic              last;
   } fcs_result_type;

   function automatic fcs_result_type mk_result(
      input logic [2:0]        kind,
      input logic [WORD_W-1:0] target,
      input logic [WORD_W-1:0] payload,
      input logic [1:0]        operation,
      input logic [2:0]        code
   );
      fcs_result_type r;
      r.kind        = kind;
      r.target      = target;
      r.payload     = payload;
      r.operation   = operation;
      r.result_code = code;
      r.last        = 1'b0;
      return r;
   endfunction

endpackage

[src/fcs_if.sv]
// Request and response channel interfaces of the flash command sequencer.
interface fcs_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [31:0] address;
   logic [31:0] word;
   logic        ctrl_locked;
   logic        ctrl_busy;
   logic        end_of_op;
   logic        prog_fault;
   logic        erase_fault;
   logic        verify_fault;
   logic        low_voltage;

   modport source (
      output valid, op, address, word, ctrl_locked, ctrl_busy, end_of_op,
             prog_fault, erase_fault, verify_fault, low_voltage,
      input  ready
   );
   modport sink (
      input  valid, op, address, word, ctrl_locked, ctrl_busy, end_of_op,
             prog_fault, erase_fault, verify_fault, low_voltage,
      output ready
   );
endinterface

interface fcs_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [31:0] target;
   logic [31:0] payload;
   logic [1:0]  operation;
   logic [2:0]  result_code;
   logic        last;

   modport source (
      output valid, kind, target, payload, operation, result_code, last,
      input  ready
   );
   modport sink (
      input  valid, kind, target, payload, operation, result_code, last,
      output ready
   );
endinterface

[src/fcs_front.sv]
// Front part: accepts requests, drops low-voltage ticks, decodes into commands.
module fcs_front
   import fcs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   fcs_req_if.sink     req_if,
   output logic        cmd_valid,
   input  logic        cmd_ready,
   output fcs_cmd_type cmd
);

   logic        cmd_valid_ff, cmd_valid_in;
   fcs_cmd_type cmd_ff, cmd_in;
   logic        accept, keep, take;

   assign take         = cmd_valid_ff && cmd_ready;
   assign req_if.ready = !cmd_valid_ff || cmd_ready;
   assign accept       = req_if.valid && req_if.ready;
   // A tick under low voltage does nothing: drop it here
   assign keep         = (req_if.op != REQ_TICK) || !req_if.low_voltage;

   always_comb begin
      cmd_in.is_req      = (req_if.op != REQ_TICK);
      cmd_in.req_op      = req_if.op - 2'd1;
      cmd_in.address     = req_if.address;
      cmd_in.word        = req_if.word;
      cmd_in.ctrl_locked = req_if.ctrl_locked;
      cmd_in.ctrl_busy   = req_if.ctrl_busy;
      cmd_in.end_of_op   = req_if.end_of_op;
      cmd_in.fault       = {req_if.verify_fault, req_if.erase_fault, req_if.prog_fault};
      cmd_valid_in       = (cmd_valid_ff && !take) || (accept && keep);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= cmd_in;
      end
   end

   assign cmd_valid = cmd_valid_ff;
   assign cmd       = cmd_ff;

endmodule

[src/fcs_queue.sv]
// Command queue between the front and back parts.
module fcs_queue
   import fcs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push_valid,
   output logic        push_ready,
   input  fcs_cmd_type push_data,
   output logic        pop_valid,
   input  logic        pop_ready,
   output fcs_cmd_type pop_data
);

   fcs_cmd_type mem_ff [CMDQ_DEPTH];
   logic [1:0]  wr_ptr_ff, wr_ptr_in;
   logic [1:0]  rd_ptr_ff, rd_ptr_in;
   logic [2:0]  count_ff, count_in;
   logic        push, pop;

   assign push_ready = (count_ff != CMDQ_FULL);
   assign pop_valid  = (count_ff != 3'd0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 2'd1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 2'd1 : rd_ptr_ff;
      count_in  = count_ff + {2'd0, push} - {2'd0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[src/fcs_back.sv]
// Back part: unlock and operation machines, configuration and result queue.
module fcs_back
   import fcs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [WORD_W-1:0] csr_wdata,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  fcs_cmd_type       cmd,
   fcs_rsp_if.source         rsp_if
);

   // Configuration
   logic [WORD_W-1:0] flash_base_ff, flash_end_ff;

   // Sequencer state
   phase_type         unlock_phase_ff, unlock_phase_in;
   logic              unlocked_ff, unlocked_in;
   phase_type         op_phase_ff [NUM_OPS];
   phase_type         op_phase_in [NUM_OPS];
   logic [2:0]        pending_ff, pending_in;
   logic [WORD_W-1:0] op_address_ff [NUM_OPS];
   logic [WORD_W-1:0] op_address_in [NUM_OPS];
   logic [WORD_W-1:0] prog_word_ff, prog_word_in;
   logic [2:0]        op_result_ff [NUM_OPS];
   logic [2:0]        op_result_in [NUM_OPS];

   // Results of the command at the queue head
   fcs_result_type    res_arr [2];
   logic [1:0]        res_n;
   logic [1:0]        k;
   logic [WORD_W-1:0] cur_addr;
   logic              any_pending, all_idle, commit;

   // Result queue
   fcs_result_type    rq_mem_ff [RESQ_DEPTH];
   logic [1:0]        rq_wr_ff, rq_wr_in;
   logic [1:0]        rq_rd_ff, rq_rd_in;
   logic [2:0]        rq_count_ff, rq_count_in;
   logic              rq_pop;

   assign cmd_ready = (rq_count_ff <= RESQ_ROOM);
   assign commit    = cmd_valid && cmd_ready;

   always_comb begin
      unlock_phase_in = unlock_phase_ff;
      unlocked_in     = unlocked_ff;
      op_phase_in     = op_phase_ff;
      pending_in      = pending_ff;
      op_address_in   = op_address_ff;
      prog_word_in    = prog_word_ff;
      op_result_in    = op_result_ff;
      res_arr[0]      = '0;
      res_arr[1]      = '0;
      res_n           = 2'd0;
      k               = OPC_PROG;
      cur_addr        = '0;
      all_idle        = 1'b0;
      any_pending     = |pending_ff;

      if (cmd.is_req) begin
         if (pending_ff[cmd.req_op]) begin
            res_arr[0] = mk_result(KIND_REPLY, '0, '0, cmd.req_op, RC_BUSY);
         end else begin
            op_address_in[cmd.req_op] = cmd.address;
            if (cmd.req_op == OPC_PROG) begin
               prog_word_in = cmd.word;
            end
            pending_in[cmd.req_op]   = 1'b1;
            op_result_in[cmd.req_op] = RC_DEFAULT;
            res_arr[0] = mk_result(KIND_REPLY, '0, '0, cmd.req_op, RC_OK);
         end
         res_n = 2'd1;
      end else begin
         unique case (unlock_phase_ff)
            PH_IDLE: begin
               if (any_pending) begin
                  unlock_phase_in = PH_CHECK;
               end
            end
            PH_CHECK: begin
               if (cmd.ctrl_locked) begin
                  res_arr[0] = mk_result(KIND_KEY, '0, KEY_FIRST, OPC_PROG, RC_DEFAULT);
                  res_arr[1] = mk_result(KIND_KEY, '0, KEY_SECOND, OPC_PROG, RC_DEFAULT);
                  res_n      = 2'd2;
               end else begin
                  unlock_phase_in = PH_WAIT;
               end
            end
            PH_WAIT: begin
               unlocked_in     = 1'b1;
               unlock_phase_in = PH_OVER;
            end
            PH_OVER: begin
               if (!any_pending) begin
                  res_arr[0]      = mk_result(KIND_RELOCK, '0, '0, OPC_PROG, RC_DEFAULT);
                  res_n           = 2'd1;
                  unlocked_in     = 1'b0;
                  unlock_phase_in = PH_IDLE;
               end
            end
            default: begin
               unlock_phase_in = PH_IDLE;
            end
         endcase

         // Operation machines, in service order; each sees the phases left by the ones before
         if (unlocked_in && !cmd.ctrl_busy) begin
            for (int i = 0; i < NUM_OPS; i++) begin
               k        = OP_ORDER[i];
               cur_addr = op_address_ff[k];
               all_idle = (op_phase_in[0] == PH_IDLE) && (op_phase_in[1] == PH_IDLE)
                          && (op_phase_in[2] == PH_IDLE);
               unique case (op_phase_in[k])
                  PH_IDLE: begin
                     if (all_idle && pending_ff[k]) begin
                        op_phase_in[k] = PH_CHECK;
                     end
                  end
                  PH_CHECK: begin
                     if ((cur_addr >= flash_base_ff) && (cur_addr < flash_end_ff)) begin
                        res_arr[res_n[0]] = mk_result(KIND_START, cur_addr, '0, k, RC_DEFAULT);
                        res_n = res_n + 2'd1;
                        if (k == OPC_PROG) begin
                           res_arr[res_n[0]] = mk_result(KIND_DATA, cur_addr, prog_word_ff,
                                                         OPC_PROG, RC_DEFAULT);
                           res_n = res_n + 2'd1;
                        end
                        op_phase_in[k] = PH_WAIT;
                     end else begin
                        op_result_in[k] = RC_ADDR_ERR;
                        op_phase_in[k]  = PH_OVER;
                     end
                  end
                  PH_WAIT: begin
                     if (cmd.end_of_op) begin
                        op_result_in[k] = cmd.fault[k] ? RC_ERROR : RC_OK;
                        op_phase_in[k]  = PH_OVER;
                     end
                  end
                  PH_OVER: begin
                     res_arr[res_n[0]] = mk_result(KIND_CLEAR, '0, '0, k, RC_DEFAULT);
                     res_n = res_n + 2'd1;
                     res_arr[res_n[0]] = mk_result(KIND_DONE, cur_addr, '0, k, op_result_ff[k]);
                     res_n = res_n + 2'd1;
                     pending_in[k]  = 1'b0;
                     op_phase_in[k] = PH_IDLE;
                  end
                  default: begin
                     op_phase_in[k] = PH_IDLE;
                  end
               endcase
            end
         end
      end

      // Mark the final result of this command
      if (res_n == 2'd2) begin
         res_arr[1].last = 1'b1;
      end else if (res_n == 2'd1) begin
         res_arr[0].last = 1'b1;
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         flash_base_ff <= FLASH_BASE_RESET;
         flash_end_ff  <= FLASH_END_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FLASH_BASE: flash_base_ff <= csr_wdata;
            CSR_FLASH_END:  flash_end_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Control state: advance only when the head command commits
   always_ff @(posedge clock) begin
      if (reset) begin
         unlock_phase_ff <= PH_IDLE;
         unlocked_ff     <= 1'b0;
         pending_ff      <= 3'd0;
         for (int i = 0; i < NUM_OPS; i++) begin
            op_phase_ff[i]  <= PH_IDLE;
            op_result_ff[i] <= RC_DEFAULT;
         end
      end else if (commit) begin
         unlock_phase_ff <= unlock_phase_in;
         unlocked_ff     <= unlocked_in;
         pending_ff      <= pending_in;
         op_phase_ff     <= op_phase_in;
         op_result_ff    <= op_result_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         op_address_ff <= op_address_in;
         prog_word_ff  <= prog_word_in;
      end
   end

   // Result queue
   assign rq_pop = rsp_if.valid && rsp_if.ready;

   always_comb begin
      rq_wr_in    = commit ? rq_wr_ff + res_n : rq_wr_ff;
      rq_rd_in    = rq_pop ? rq_rd_ff + 2'd1 : rq_rd_ff;
      rq_count_in = rq_count_ff + (commit ? {1'b0, res_n} : 3'd0) - {2'd0, rq_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rq_wr_ff    <= 2'd0;
         rq_rd_ff    <= 2'd0;
         rq_count_ff <= 3'd0;
      end else begin
         rq_wr_ff    <= rq_wr_in;
         rq_rd_ff    <= rq_rd_in;
         rq_count_ff <= rq_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit && (res_n != 2'd0)) begin
         rq_mem_ff[rq_wr_ff] <= res_arr[0];
      end
      if (commit && (res_n == 2'd2)) begin
         rq_mem_ff[rq_wr_ff + 2'd1] <= res_arr[1];
      end
   end

   assign rsp_if.valid       = (rq_count_ff != 3'd0);
   assign rsp_if.kind        = rq_mem_ff[rq_rd_ff].kind;
   assign rsp_if.target      = rq_mem_ff[rq_rd_ff].target;
   assign rsp_if.payload     = rq_mem_ff[rq_rd_ff].payload;
   assign rsp_if.operation   = rq_mem_ff[rq_rd_ff].operation;
   assign rsp_if.result_code = rq_mem_ff[rq_rd_ff].result_code;
   assign rsp_if.last        = rq_mem_ff[rq_rd_ff].last;

endmodule

[src/flash_command_sequencer.sv]
// Top level of the flash command sequencer: front, command queue and back.
//
// Use:
//   req_if carries requests (program, erase, erase verify) and ticks holding the
//   controller status bits; rsp_if returns replies, key writes, start commands,
//   data writes, clear controls, relocks and completions, with last set on the
//   final result of each request. A request causes zero, one or two results.
//   csr_we/csr_index/csr_wdata write flash_base (index 0) and flash_end (index 1);
//   write them only while the block is idle.
// Timing:
//   A request is taken every cycle while the command queue has room. A result
//   passes through one register stage each in the front, the command queue and
//   the result queue before it is presented. The response port moves one result
//   a cycle while rsp_if.ready is high, so the two results of a request leave
//   that port one after the other.
// Reset:
//   Synchronous, active high. Clears the queues, the unlock and operation
//   machines and the pending flags, and loads the default flash window.
// Stall:
//   When rsp_if.ready is low the result queue fills, the back part stops
//   committing, the command queue fills and then req_if.ready drops.
module flash_command_sequencer
   import fcs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   fcs_req_if.sink           req_if,
   fcs_rsp_if.source         rsp_if,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [WORD_W-1:0] csr_wdata
);

   // Front to queue
   logic        front_valid, front_ready;
   fcs_cmd_type front_cmd;

   // Queue to back
   logic        head_valid, head_ready;
   fcs_cmd_type head_cmd;

   // Accept, classify and register each request; low-voltage ticks are dropped here
   fcs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .cmd_valid (front_valid),
      .cmd_ready (front_ready),
      .cmd       (front_cmd)
   );

   // Decouple the front from stalls in the back
   fcs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_cmd),
      .pop_valid  (head_valid),
      .pop_ready  (head_ready),
      .pop_data   (head_cmd)
   );

   // Run the unlock and operation machines, one command per cycle while the result queue has room
   fcs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd_valid (head_valid),
      .cmd_ready (head_ready),
      .cmd       (head_cmd),
      .rsp_if    (rsp_if)
   );

endmodule
